/* design/mb2hs_pkg.sv */
// ----------------------------------------------------------------------------
// mb2hs_pkg: shared definitions for the Multiboot2 header scanner
// Holds the scan phases, result status codes and the header format constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mb2hs_pkg;

    // Search window for the header, in bytes from the start of the image.
    localparam int unsigned SEARCH_LIMIT_BYTES = 32768;

    // Width of a stored header offset; the header starts below the window.
    localparam int unsigned FOUND_W = $clog2(SEARCH_LIMIT_BYTES);

    // Width of the reported header offset.
    localparam int unsigned HDR_OFF_W = 15;

    // Header format constants.
    localparam logic [31:0] MB2_MAGIC      = 32'hE852_50D6;
    localparam logic [31:0] HDR_FIXED_LEN  = 32'd16;
    localparam logic [31:0] TAG_MIN_SIZE   = 32'd8;
    localparam logic [31:0] TAG_ALIGN_MASK = 32'd7;
    localparam logic [31:0] POS_SATURATE   = 32'hFFFF_FFFC;
    localparam logic [31:0] WORD_BYTES     = 32'd4;

    // Scan phases, one per header word being examined.
    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_ARCH    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CSUM    = 3'd3,
        PH_TAGTYPE = 3'd4,
        PH_TAGSIZE = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_ARCH     = 3'd2,
        ST_LEN      = 3'd3,
        ST_CSUM     = 3'd4,
        ST_TAG      = 3'd5
    } status_t;

endpackage

`default_nettype wire

/* design/multiboot2_header_scan.sv */
// ----------------------------------------------------------------------------
// multiboot2_header_scan: streaming Multiboot2 header check
// Scans an image word stream for the header, validates it and walks its tags.
// ----------------------------------------------------------------------------
// Usage:
//   The image arrives on the s_ channel as little-endian 32-bit words, one
//   word per accepted handshake, with s_last marking the final word. Before an
//   image starts, cfg_wdata is written with cfg_we to give the image size in
//   bytes. For every image exactly one result word leaves on the m_ channel:
//   a status and, when the status is ok, the byte offset of the header.
//   Timing: a word is captured in the input register at the edge that
//   accepts it and is evaluated while it is held there; the result register
//   loads at the edge that takes the deciding word out of the input register,
//   and m_valid is driven from the result register.
//   Throughput: one word per cycle; the per-word evaluation (compares and a
//   32-bit add on the header state) sits between the input register and the
//   result register. Words after the decision are consumed without output.
//   When the receiver stalls, the result register holds its word and the
//   input register buffers one more word; after that s_ready drops.
//   Reset clears the scan state, the size register and both registers' valid
//   flags. After each last word the scan state returns to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module multiboot2_header_scan
    import mb2hs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_wdata,
    // Image word input
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [31:0]          s_data_word,
    input  wire logic                 s_last,
    // Result output
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [2:0]                m_status,
    output logic [HDR_OFF_W-1:0]      m_header_offset
);

    // Registers.
    logic [31:0]          image_bytes_reg;
    logic                 in_valid_reg;
    logic [31:0]          in_word_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [HDR_OFF_W-1:0] out_offset_reg;

    phase_t               phase_reg, phase_next;
    logic [31:0]          byte_pos_reg, byte_pos_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic [31:0]          hdr_len_reg, hdr_len_next;
    logic [31:0]          hdr_sum_reg, hdr_sum_next;
    logic [31:0]          next_tag_reg, next_tag_next;
    logic [31:0]          tag_rel_reg, tag_rel_next;
    logic                 tag_end_reg, tag_end_next;
    logic                 settled_reg, settled_next;

    logic                 emit;
    status_t              emit_status;
    logic                 proc;
    logic                 accept;

    // Handshake: the input register is free or empties this cycle.
    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign accept  = s_valid && s_ready;

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_header_offset = out_offset_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_bytes_reg <= '0;
        end else if (cfg_we) begin
            image_bytes_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_word_reg <= s_data_word;
            in_last_reg <= s_last;
        end
    end

    // Scan state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEARCH;
            byte_pos_reg <= '0;
            found_reg    <= '0;
            hdr_len_reg  <= '0;
            hdr_sum_reg  <= '0;
            next_tag_reg <= '0;
            tag_rel_reg  <= '0;
            tag_end_reg  <= 1'b0;
            settled_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            found_reg    <= found_next;
            hdr_len_reg  <= hdr_len_next;
            hdr_sum_reg  <= hdr_sum_next;
            next_tag_reg <= next_tag_next;
            tag_rel_reg  <= tag_rel_next;
            tag_end_reg  <= tag_end_next;
            settled_reg  <= settled_next;
        end
    end

    // Per-word evaluation of the header state.
    always_comb begin
        logic [31:0] w;
        logic [31:0] limit;
        logic [31:0] found32;
        logic [31:0] sum_csum;
        logic [32:0] len_end;
        logic [32:0] search_end;
        logic [32:0] tag_end_pos;
        logic [32:0] tag_step;
        logic [32:0] tag_after;
        logic        done;

        w          = in_word_reg;
        limit      = (image_bytes_reg < 32'(SEARCH_LIMIT_BYTES)) ?
                     image_bytes_reg : 32'(SEARCH_LIMIT_BYTES);
        found32    = 32'(found_reg);
        sum_csum   = hdr_sum_reg + w;
        len_end    = {1'b0, found32} + {1'b0, w};
        search_end = {1'b0, byte_pos_reg} + {1'b0, HDR_FIXED_LEN};
        tag_end_pos = {1'b0, tag_rel_reg} + {1'b0, w};
        tag_step   = ({1'b0, w} + {1'b0, TAG_ALIGN_MASK}) & ~{1'b0, TAG_ALIGN_MASK};
        tag_after  = {1'b0, tag_rel_reg} + tag_step;
        done       = 1'b0;

        phase_next    = phase_reg;
        byte_pos_next = byte_pos_reg;
        found_next    = found_reg;
        hdr_len_next  = hdr_len_reg;
        hdr_sum_next  = hdr_sum_reg;
        next_tag_next = next_tag_reg;
        tag_rel_next  = tag_rel_reg;
        tag_end_next  = tag_end_reg;
        settled_next  = settled_reg;
        emit_status   = ST_NOTFOUND;
        emit          = 1'b0;

        if (proc) begin
            if (!settled_reg) begin
                case (phase_reg)
                    PH_SEARCH: begin
                        if ((byte_pos_reg[2:0] == 3'd0) && (search_end <= {1'b0, limit})
                            && (w == MB2_MAGIC)) begin
                            found_next   = byte_pos_reg[FOUND_W-1:0];
                            hdr_sum_next = w;
                            phase_next   = PH_ARCH;
                        end
                    end
                    PH_ARCH: begin
                        if (w != '0) begin
                            done        = 1'b1;
                            emit_status = ST_ARCH;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        hdr_len_next = w;
                        hdr_sum_next = sum_csum;
                        if ((w < HDR_FIXED_LEN) || (len_end > {1'b0, image_bytes_reg})) begin
                            done        = 1'b1;
                            emit_status = ST_LEN;
                        end else begin
                            phase_next = PH_CSUM;
                        end
                    end
                    PH_CSUM: begin
                        hdr_sum_next = sum_csum;
                        if (sum_csum != '0) begin
                            done        = 1'b1;
                            emit_status = ST_CSUM;
                        end else if (hdr_len_reg <= HDR_FIXED_LEN) begin
                            done        = 1'b1;
                            emit_status = ST_OK;
                        end else begin
                            next_tag_next = found32 + HDR_FIXED_LEN;
                            tag_rel_next  = HDR_FIXED_LEN;
                            phase_next    = PH_TAGTYPE;
                        end
                    end
                    PH_TAGTYPE: begin
                        if (byte_pos_reg == next_tag_reg) begin
                            tag_end_next = (w[15:0] == 16'd0);
                            phase_next   = PH_TAGSIZE;
                        end
                    end
                    PH_TAGSIZE: begin
                        if ((w < TAG_MIN_SIZE) || (tag_end_pos > {1'b0, hdr_len_reg})) begin
                            done        = 1'b1;
                            emit_status = ST_TAG;
                        end else if (tag_end_reg) begin
                            done        = 1'b1;
                            emit_status = ST_OK;
                        end else if (tag_after >= {1'b0, hdr_len_reg}) begin
                            done        = 1'b1;
                            emit_status = ST_OK;
                        end else begin
                            tag_rel_next  = tag_after[31:0];
                            next_tag_next = next_tag_reg + tag_step[31:0];
                            phase_next    = PH_TAGTYPE;
                        end
                    end
                    default: begin
                        phase_next = PH_SEARCH;
                    end
                endcase

                // A stream that ends undecided reports not found.
                if (!done && in_last_reg) begin
                    done        = 1'b1;
                    emit_status = ST_NOTFOUND;
                end
                if (done) begin
                    emit         = 1'b1;
                    settled_next = 1'b1;
                end
            end

            // Word position, saturating near the top of the address range.
            if (byte_pos_reg < POS_SATURATE) begin
                byte_pos_next = byte_pos_reg + WORD_BYTES;
            end

            // The last word returns the scan to its starting state.
            if (in_last_reg) begin
                phase_next    = PH_SEARCH;
                byte_pos_next = '0;
                found_next    = '0;
                hdr_len_next  = '0;
                hdr_sum_next  = '0;
                next_tag_next = '0;
                tag_rel_next  = '0;
                tag_end_next  = 1'b0;
                settled_next  = 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic [31:0] off32;
        off32 = 32'(found_reg);
        if (proc && emit) begin
            out_status_reg <= emit_status;
            out_offset_reg <= (emit_status == ST_OK) ? off32[HDR_OFF_W-1:0] : '0;
        end
    end

    // Checks on the scan logic.
    a_offset_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_header_offset == '0))
        else $error("header offset reported with a failing status");

    a_settle_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && emit && !in_last_reg) |=> settled_reg)
        else $error("scan not settled after giving its result");

    a_found_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_SEARCH) |-> (found_reg[2:0] == 3'd0))
        else $error("header offset is not 8-byte aligned");

    a_tag_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_TAGTYPE) || (phase_reg == PH_TAGSIZE))
        |-> ((next_tag_reg[2:0] == 3'd0) && (tag_rel_reg < hdr_len_reg)))
        else $error("tag position misaligned or outside the header");

endmodule

`default_nettype wire
